### rtl/crp_pkg.sv
// crp_pkg: shared types and constants for the COFF relocation patch block.
// Holds relocation type codes, machine codes and the item/result/CSR structs.
// No dependencies.
package crp_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned KIND_W = 5;
   localparam int unsigned SECT_W = 16;

   // machine_mode codes
   localparam logic MACH_X86 = 1'b0;
   localparam logic MACH_ARM = 1'b1;

   // CSR indexes
   localparam logic CSR_MACHINE_MODE = 1'b0;
   localparam logic CSR_LOAD_BASE    = 1'b1;

   // x86 relocation type codes
   localparam logic [KIND_W-1:0] X86_ABS     = 5'd0;
   localparam logic [KIND_W-1:0] X86_DIR32   = 5'd6;
   localparam logic [KIND_W-1:0] X86_DIR32NB = 5'd7;
   localparam logic [KIND_W-1:0] X86_SECTION = 5'd10;
   localparam logic [KIND_W-1:0] X86_SECREL  = 5'd11;
   localparam logic [KIND_W-1:0] X86_REL32   = 5'd20;

   // ARM relocation type codes
   localparam logic [KIND_W-1:0] ARM_ABS      = 5'd0;
   localparam logic [KIND_W-1:0] ARM_ADDR32   = 5'd1;
   localparam logic [KIND_W-1:0] ARM_ADDR32NB = 5'd2;
   localparam logic [KIND_W-1:0] ARM_BRANCH24 = 5'd3;
   localparam logic [KIND_W-1:0] ARM_SECTION  = 5'd14;
   localparam logic [KIND_W-1:0] ARM_SECREL   = 5'd15;

   localparam logic [WORD_W-1:0] LOAD_BASE_RESET = 32'h0040_0000;
   localparam logic [WORD_W-1:0] BRANCH_MASK     = 32'h00FF_FFFF;
   localparam logic [WORD_W-1:0] ARM_PC_AHEAD    = 32'd8;
   localparam logic [WORD_W-1:0] X86_PC_AHEAD    = 32'd4;

   typedef struct packed {
      logic              machine_mode;
      logic [WORD_W-1:0] load_base;
   } crp_csr_type;

   typedef struct packed {
      logic [WORD_W-1:0] orig_word;
      logic [KIND_W-1:0] reloc_kind;
      logic [WORD_W-1:0] symbol_value;
      logic              symbol_is_absolute;
      logic [SECT_W-1:0] symbol_section;
      logic [WORD_W-1:0] section_base;
      logic [WORD_W-1:0] site_address;
   } crp_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] patched_word;
      logic              base_reloc_request;
      logic              unknown_kind;
   } crp_result_type;

endpackage

### rtl/crp_csr.sv
// crp_csr: configuration registers (machine_mode, preferred load base).
// Depends on crp_pkg.
module crp_csr
   import crp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [WORD_W-1:0] csr_wdata,
   output crp_csr_type       csr
);

   logic              machine_mode_ff, machine_mode_in;
   logic [WORD_W-1:0] load_base_ff, load_base_in;

   always_comb begin
      machine_mode_in = machine_mode_ff;
      load_base_in    = load_base_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MACHINE_MODE: machine_mode_in = csr_wdata[0];
            CSR_LOAD_BASE:    load_base_in    = csr_wdata;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         machine_mode_ff <= MACH_X86;
         load_base_ff    <= LOAD_BASE_RESET;
      end else begin
         machine_mode_ff <= machine_mode_in;
         load_base_ff    <= load_base_in;
      end
   end

   assign csr.machine_mode = machine_mode_ff;
   assign csr.load_base    = load_base_ff;

endmodule

### rtl/crp_alu.sv
// crp_alu: combinational relocation arithmetic for one item.
// Depends on crp_pkg.
module crp_alu
   import crp_pkg::*;
(
   input  crp_csr_type    csr,
   input  crp_item_type   item,
   output crp_result_type result
);

   logic [KIND_W-1:0] kind;
   logic [WORD_W-1:0] w;
   logic [WORD_W-1:0] s;
   logic [WORD_W-1:0] sum_abs;
   logic [WORD_W-1:0] sum_nb;
   logic [WORD_W-1:0] rel32;
   logic [WORD_W-1:0] br_off;
   logic [WORD_W-1:0] branch;
   logic [WORD_W-1:0] secrel;
   logic [WORD_W-1:0] section;

   assign w = item.orig_word;
   assign s = item.symbol_value;

   // absolute symbol forces ABS (code 0 on both machines)
   assign kind = item.symbol_is_absolute ? X86_ABS : item.reloc_kind;

   assign sum_nb  = w + s;
   assign sum_abs = sum_nb + csr.load_base;
   assign rel32   = w + (s - item.site_address - X86_PC_AHEAD);
   assign br_off  = s - item.site_address - ARM_PC_AHEAD;
   assign branch  = w | ({2'b00, br_off[WORD_W-1:2]} & BRANCH_MASK);
   assign secrel  = s - item.section_base;
   assign section = {w[WORD_W-1:SECT_W], item.symbol_section};

   always_comb begin
      result.patched_word       = w;
      result.base_reloc_request = 1'b0;
      result.unknown_kind       = 1'b0;
      if (csr.machine_mode == MACH_X86) begin
         case (kind)
            X86_DIR32: begin
               result.patched_word       = sum_abs;
               result.base_reloc_request = 1'b1;
            end
            X86_DIR32NB: result.patched_word = sum_nb;
            X86_REL32:   result.patched_word = rel32;
            X86_ABS:     result.patched_word = s;
            X86_SECREL:  result.patched_word = secrel;
            X86_SECTION: result.patched_word = section;
            default:     result.unknown_kind = 1'b1;
         endcase
      end else begin
         case (kind)
            ARM_ADDR32:   result.patched_word = sum_abs;
            ARM_ADDR32NB: result.patched_word = sum_nb;
            ARM_BRANCH24: result.patched_word = branch;
            ARM_ABS:      result.patched_word = s;
            ARM_SECREL:   result.patched_word = secrel;
            ARM_SECTION:  result.patched_word = section;
            default:      result.unknown_kind = 1'b1;
         endcase
      end
   end

endmodule

### rtl/coff_relocation_patch.sv
// coff_relocation_patch: top level, input register, result register, handshake.
// Depends on crp_pkg, crp_csr and crp_alu.
//
// Usage:
//  - req_ channel: one relocation per transfer. tdata carries the site word,
//    symbol value, section number, section base and site address; tuser
//    carries the type code and the absolute-symbol flag.
//  - rsp_ channel: one result per transfer: patched word in tdata, the
//    base-relocation request and unknown-type flags in tuser.
//  - csr_ port: write machine_mode (index 0) or the preferred load base
//    (index 1) while no transfer is in flight.
//  - Path: a request accepted into the input register passes the relocation
//    adder/mux into the result register, which drives rsp_tvalid.
//  - Throughput: one transfer per cycle while rsp_tready is high; the single adder/mux pass
//    between the two registers sets that rate.
//  - Stall: while rsp_tready is low a full result register holds; req_tready
//    stays high while the input register can drain or is empty, so up to two
//    items are buffered before back-pressure reaches req_.
//  - Reset: synchronous, clears both valid flags and loads machine_mode = x86,
//    load base = 0x00400000.
module coff_relocation_patch
   import crp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // orig_word[31:0], symbol_value[63:32], symbol_section[79:64],
   // section_base[111:80], site_address[143:112]
   input  logic [143:0] req_tdata,
   // reloc_kind[4:0], symbol_is_absolute[5]
   input  logic [5:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // patched_word[31:0]
   output logic [31:0]  rsp_tdata,
   // base_reloc_request[0], unknown_kind[1]
   output logic [1:0]   rsp_tuser,
   // configuration
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);

   crp_csr_type    csr;
   crp_item_type   req_item;
   crp_result_type alu_result;

   logic           s1_valid_ff, s1_valid_in;
   crp_item_type   s1_item_ff, s1_item_in;
   logic           s2_valid_ff, s2_valid_in;
   crp_result_type s2_result_ff, s2_result_in;

   logic           s2_load;
   logic           s1_load;

   crp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   // unpack request transfer
   assign req_item.orig_word          = req_tdata[31:0];
   assign req_item.symbol_value       = req_tdata[63:32];
   assign req_item.symbol_section     = req_tdata[79:64];
   assign req_item.section_base       = req_tdata[111:80];
   assign req_item.site_address       = req_tdata[143:112];
   assign req_item.reloc_kind         = req_tuser[4:0];
   assign req_item.symbol_is_absolute = req_tuser[5];

   crp_alu u_alu (
      .csr    (csr),
      .item   (s1_item_ff),
      .result (alu_result)
   );

   // stage advance: result register frees when empty or taken
   assign s2_load    = !s2_valid_ff || rsp_tready;
   assign s1_load    = !s1_valid_ff || s2_load;
   assign req_tready = s1_load;

   always_comb begin
      s1_valid_in  = s1_load ? req_tvalid : s1_valid_ff;
      s1_item_in   = (s1_load && req_tvalid) ? req_item : s1_item_ff;
      s2_valid_in  = s2_load ? s1_valid_ff : s2_valid_ff;
      s2_result_in = (s2_load && s1_valid_ff) ? alu_result : s2_result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_item_ff   <= s1_item_in;
      s2_result_ff <= s2_result_in;
   end

   assign rsp_tvalid   = s2_valid_ff;
   assign rsp_tdata    = s2_result_ff.patched_word;
   assign rsp_tuser[0] = s2_result_ff.base_reloc_request;
   assign rsp_tuser[1] = s2_result_ff.unknown_kind;

   // a full input stage always moves into an empty result stage
   a_s1_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_valid_ff |=> s2_valid_ff)
      else $error("input stage failed to advance into empty result stage");

   // an unknown type never requests a base relocation
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> !(s2_result_ff.unknown_kind && s2_result_ff.base_reloc_request))
      else $error("unknown type raised a base relocation request");

   // base relocation requests come only from x86 mode
   a_breq_x86: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_result_ff.base_reloc_request |-> csr.machine_mode == MACH_X86)
      else $error("base relocation request outside x86 mode");

   // after reset nothing is presented
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s2_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

### sim/tb_coff_relocation_patch.sv
// tb_coff_relocation_patch: self-checking testbench for the COFF relocation patch block.
// Predicts each patched word from the crp_pkg type codes and checks it on the rsp_ stream.
// Depends on crp_pkg and coff_relocation_patch.
`timescale 1ns / 100ps

module tb_coff_relocation_patch;
   import crp_pkg::*;

   // ---------------------------------------------------------------------------
   // DUT ports; every input holds a known value from time zero
   // ---------------------------------------------------------------------------
   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata  = '0;   // orig_word, symbol_value, symbol_section,
                                    // section_base, site_address (low to high)
   logic [5:0]   req_tuser  = '0;   // reloc_kind, symbol_is_absolute (low to high)
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;         // patched_word
   logic [1:0]   rsp_tuser;         // base_reloc_request, unknown_kind (low to high)
   logic         csr_we     = 1'b0;
   logic         csr_index  = 1'b0;
   logic [31:0]  csr_wdata  = '0;

   coff_relocation_patch DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Shared state between the stimulus, the receiver pacing and the checker
   // ---------------------------------------------------------------------------
   logic              cfg_mode      = MACH_X86;         // shadow of machine_mode
   logic [WORD_W-1:0] cfg_load_base = LOAD_BASE_RESET;  // shadow of the load base
   crp_result_type    pending_patches[$];               // patches owed by the DUT
   int                mismatch_count  = 0;
   bit                quiet_mode      = 1'b0;  // no sender gaps, receiver ready unless held off
   int                hold_off_cycles = 0;     // long receiver stall, consumed by receiver
   int                burst_left      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous ceiling for the ~750 transfers with stalls.
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Predictor: what the block must write back at the relocation site
   // ---------------------------------------------------------------------------
   function automatic crp_result_type predict_patch(input crp_item_type it,
                                                     input logic mode,
                                                     input logic [WORD_W-1:0] img_base);
      crp_result_type    r;
      logic [KIND_W-1:0] k;
      logic [WORD_W-1:0] w, s, p, branch_off;
      w = it.orig_word;
      s = it.symbol_value;
      p = it.site_address;
      r.patched_word       = w;
      r.base_reloc_request = 1'b0;
      r.unknown_kind       = 1'b0;
      // absolute symbols ignore the type code and take ABS on either machine
      if (it.symbol_is_absolute)
         k = (mode == MACH_ARM) ? ARM_ABS : X86_ABS;
      else
         k = it.reloc_kind;
      if (mode == MACH_X86) begin
         case (k)
            X86_DIR32: begin
               r.patched_word       = w + s + img_base;
               r.base_reloc_request = 1'b1;
            end
            X86_DIR32NB: r.patched_word = w + s;
            X86_REL32:   r.patched_word = w + (s - p - X86_PC_AHEAD);
            X86_ABS:     r.patched_word = s;
            X86_SECREL:  r.patched_word = s - it.section_base;
            X86_SECTION: r.patched_word = {w[31:16], it.symbol_section};
            default:     r.unknown_kind = 1'b1;
         endcase
      end else begin
         case (k)
            ARM_ADDR32:   r.patched_word = w + s + img_base;   // no base reloc on ARM
            ARM_ADDR32NB: r.patched_word = w + s;
            ARM_BRANCH24: begin
               branch_off     = s - p - ARM_PC_AHEAD;
               r.patched_word = w | ((branch_off >> 2) & BRANCH_MASK);
            end
            ARM_ABS:      r.patched_word = s;
            ARM_SECREL:   r.patched_word = s - it.section_base;
            ARM_SECTION:  r.patched_word = {w[31:16], it.symbol_section};
            default:      r.unknown_kind = 1'b1;
         endcase
      end
      return r;
   endfunction

   function automatic crp_item_type make_reloc(input logic [31:0] w,
                                                input logic [KIND_W-1:0] kind,
                                                input logic [31:0] s,
                                                input logic abs_sym,
                                                input logic [15:0] sec,
                                                input logic [31:0] base,
                                                input logic [31:0] site);
      crp_item_type it;
      it.orig_word          = w;
      it.reloc_kind         = kind;
      it.symbol_value       = s;
      it.symbol_is_absolute = abs_sym;
      it.symbol_section     = sec;
      it.section_base       = base;
      it.site_address       = site;
      return it;
   endfunction

   // Address-like word; corner values show up often so carries and wraps get hit.
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000 ^ $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // Mostly legal codes for the current machine, some arbitrary codes,
   // a few absolute symbols.
   function automatic crp_item_type rand_item(input logic mode);
      crp_item_type      it;
      logic [KIND_W-1:0] kind;
      int                pick;
      pick = $urandom_range(0, 5);
      if ($urandom_range(0, 9) < 8) begin
         if (mode == MACH_ARM)
            kind = (pick == 0) ? ARM_ABS : (pick == 1) ? ARM_ADDR32 :
                   (pick == 2) ? ARM_ADDR32NB : (pick == 3) ? ARM_BRANCH24 :
                   (pick == 4) ? ARM_SECTION : ARM_SECREL;
         else
            kind = (pick == 0) ? X86_ABS : (pick == 1) ? X86_DIR32 :
                   (pick == 2) ? X86_DIR32NB : (pick == 3) ? X86_REL32 :
                   (pick == 4) ? X86_SECTION : X86_SECREL;
      end else begin
         kind = 5'($urandom_range(0, 31));
      end
      it = make_reloc(rand_word(), kind, rand_word(), $urandom_range(0, 9) == 0,
                      16'($urandom_range(0, 65535)), rand_word(), rand_word());
      // near branches/calls: site close to the target, either direction
      if ($urandom_range(0, 1))
         it.site_address = it.symbol_value + $urandom_range(0, 8192) - 4096;
      case ($urandom_range(0, 7))
         0: it.symbol_section = 16'h0000;
         1: it.symbol_section = 16'hFFFF;
         default: ;
      endcase
      return it;
   endfunction

   // ---------------------------------------------------------------------------
   // Sender: one relocation per call, bursts with random gaps in between.
   // Entered and left just after a falling edge.
   // ---------------------------------------------------------------------------
   task automatic offer_reloc(input crp_item_type it);
      int gap;
      if (!quiet_mode) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      req_tdata  <= {it.site_address, it.section_base, it.symbol_section,
                     it.symbol_value, it.orig_word};
      req_tuser  <= {it.symbol_is_absolute, it.reloc_kind};
      req_tvalid <= 1'b1;
      // transfer happens on the first rising edge with tready high
      do @(posedge clock); while (!req_tready);
      pending_patches.push_back(predict_patch(it, cfg_mode, cfg_load_base));
      @(negedge clock);
   endtask

   // Stop offering, wait for every owed result, then let the pipe settle.
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (pending_patches.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes both registers back to back; only called with the pipe empty.
   // Bits above bit 0 of the mode write are don't-care and get random values.
   task automatic configure(input logic mode, input logic [31:0] img_base);
      csr_we    <= 1'b1;
      csr_index <= CSR_MACHINE_MODE;
      csr_wdata <= {31'($urandom_range(0, 32'h7FFF_FFFF)), mode};
      @(negedge clock);
      csr_index <= CSR_LOAD_BASE;
      csr_wdata <= img_base;
      @(negedge clock);
      csr_we    <= 1'b0;
      cfg_mode      = mode;
      cfg_load_base = img_base;
   endtask

   // ---------------------------------------------------------------------------
   // Receiver pacing: rotating ready pattern, reshuffled now and then; a long
   // hold-off counted here when a test asks for one.
   // ---------------------------------------------------------------------------
   initial begin : receiver_pace
      logic [15:0] ready_pattern;
      int          pattern_age;
      ready_pattern = 16'hFFFF;
      pattern_age   = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            if (pattern_age == 0) begin
               ready_pattern = 16'($urandom) | 16'h0001;
               pattern_age   = $urandom_range(16, 96);
            end
            pattern_age--;
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            rsp_tready <= quiet_mode | ready_pattern[0];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Checker: every transfer on rsp_ against the oldest owed patch
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_result
      crp_result_type seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.patched_word       = rsp_tdata;
         seen.base_reloc_request = rsp_tuser[0];
         seen.unknown_kind       = rsp_tuser[1];
         if (pending_patches.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%t: result with none owed: word %h breq %b unk %b", $realtime,
                        seen.patched_word, seen.base_reloc_request, seen.unknown_kind);
         end else begin
            want = pending_patches.pop_front();
            if (seen.patched_word !== want.patched_word ||
                seen.base_reloc_request !== want.base_reloc_request ||
                seen.unknown_kind !== want.unknown_kind) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t: mismatch: want word %h breq %b unk %b, got %h %b %b",
                           $realtime, want.patched_word, want.base_reloc_request,
                           want.unknown_kind, seen.patched_word,
                           seen.base_reloc_request, seen.unknown_kind);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset configuration (x86, load base 0x00400000): every x86 type at its
   // extremes, absolute override, codes unknown on x86.
   task automatic test_x86_directed();
      offer_reloc(make_reloc(32'h1234_5678, X86_DIR32, 32'h0000_1000, 1'b0, 16'd1,
                             32'h0, 32'h0));
      offer_reloc(make_reloc(32'hFFFF_FFFF, X86_DIR32, 32'hFFFF_FFFF, 1'b0, 16'd1,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF));              // carry out
      offer_reloc(make_reloc(32'h0, X86_DIR32NB, 32'h0, 1'b0, 16'd0, 32'h0, 32'h0));
      offer_reloc(make_reloc(32'hFFFF_FFFF, X86_DIR32NB, 32'h0000_0001, 1'b0, 16'd2,
                             32'h0, 32'h0));
      offer_reloc(make_reloc(32'hFFFF_FFFF, X86_REL32, 32'h0, 1'b0, 16'd1,
                             32'h0, 32'hFFFF_FFFF));                      // wraps
      offer_reloc(make_reloc(32'h0, X86_REL32, 32'h0040_1000, 1'b0, 16'd1,
                             32'h0, 32'h0040_2000));                      // backward call
      offer_reloc(make_reloc(32'hDEAD_BEEF, X86_ABS, 32'hFFFF_FFFF, 1'b0, 16'hFFFF,
                             32'h0, 32'h0));
      offer_reloc(make_reloc(32'h0, X86_SECREL, 32'h0000_0010, 1'b0, 16'd3,
                             32'h0000_0020, 32'h0));                      // below base
      offer_reloc(make_reloc(32'hFFFF_FFFF, X86_SECTION, 32'h0, 1'b0, 16'h0000,
                             32'h0, 32'h0));
      offer_reloc(make_reloc(32'h0, X86_SECTION, 32'hFFFF_FFFF, 1'b0, 16'hFFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF));
      // absolute symbol: type ignored, no base reloc, never unknown
      offer_reloc(make_reloc(32'h1111_1111, X86_DIR32, 32'h2222_2222, 1'b1, 16'd1,
                             32'h0, 32'h0));
      offer_reloc(make_reloc(32'h1111_1111, 5'd31, 32'h3333_3333, 1'b1, 16'd1,
                             32'h0, 32'h0));
      // unknown codes, including an ARM-only one
      offer_reloc(make_reloc(32'hCAFE_F00D, 5'd31, 32'h1, 1'b0, 16'd1, 32'h0, 32'h0));
      offer_reloc(make_reloc(32'hCAFE_F00D, ARM_ADDR32, 32'h1, 1'b0, 16'd1, 32'h0, 32'h0));
   endtask

   // ARM with load base all ones: every ARM type, branch both ways, codes
   // that ARM does not know.
   task automatic test_arm_directed();
      drain_pipe();
      configure(MACH_ARM, 32'hFFFF_FFFF);
      offer_reloc(make_reloc(32'h0000_0004, ARM_ADDR32, 32'h0000_1000, 1'b0, 16'd1,
                             32'h0, 32'h0));                              // no base reloc
      offer_reloc(make_reloc(32'hFFFF_FFFF, ARM_ADDR32NB, 32'hFFFF_FFFF, 1'b0, 16'd1,
                             32'h0, 32'h0));
      offer_reloc(make_reloc(32'hEB00_0000, ARM_BRANCH24, 32'h0001_0000, 1'b0, 16'd1,
                             32'h0, 32'h0000_8000));                      // forward
      offer_reloc(make_reloc(32'hEB00_0000, ARM_BRANCH24, 32'h0000_1000, 1'b0, 16'd1,
                             32'h0, 32'h0000_9000));                      // backward
      offer_reloc(make_reloc(32'hFF00_0000, ARM_BRANCH24, 32'h0, 1'b0, 16'd1,
                             32'h0, 32'hFFFF_FFFF));
      offer_reloc(make_reloc(32'h0, ARM_ABS, 32'h8000_0000, 1'b0, 16'd1, 32'h0, 32'h0));
      offer_reloc(make_reloc(32'h0, ARM_SECREL, 32'h1000_0000, 1'b0, 16'd2,
                             32'hFFFF_F000, 32'h0));
      offer_reloc(make_reloc(32'hABCD_0000, ARM_SECTION, 32'h0, 1'b0, 16'hFFFF,
                             32'h0, 32'h0));
      offer_reloc(make_reloc(32'hEB00_0000, ARM_BRANCH24, 32'h5555_5555, 1'b1, 16'd1,
                             32'h0, 32'h0));                              // absolute
      offer_reloc(make_reloc(32'h1234_5678, X86_DIR32, 32'h1, 1'b0, 16'd1, 32'h0, 32'h0));
      offer_reloc(make_reloc(32'h1234_5678, 5'd31, 32'h1, 1'b0, 16'd1, 32'h0, 32'h0));
   endtask

   task automatic test_random_stream(input logic mode, input logic [31:0] img_base,
                                     input int count);
      drain_pipe();
      configure(mode, img_base);
      repeat (count) offer_reloc(rand_item(cfg_mode));
   endtask

   // Receiver stops for a long stretch while the sender keeps offering, so the
   // two internal stages fill and req_tready drops.
   task automatic test_backpressure();
      drain_pipe();
      configure(MACH_X86, LOAD_BASE_RESET);
      quiet_mode      = 1'b1;
      hold_off_cycles = 150;
      repeat (100) offer_reloc(rand_item(cfg_mode));
      quiet_mode = 1'b0;
   endtask

   // Back-to-back transfers, receiver always ready.
   task automatic test_full_rate();
      drain_pipe();
      configure(MACH_ARM, 32'h8000_0000);
      quiet_mode = 1'b1;
      repeat (120) offer_reloc(rand_item(cfg_mode));
      quiet_mode = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_x86_directed();
      test_arm_directed();
      test_random_stream(MACH_X86, 32'h0000_0000, 200);
      test_random_stream(MACH_ARM, $urandom, 200);
      test_backpressure();
      test_full_rate();
      test_random_stream(MACH_X86, 32'hFFFF_FFFF, 130);

      drain_pipe();
      if (pending_patches.size() != 0)
         $display("%0d results never arrived", pending_patches.size());
      if (mismatch_count == 0 && pending_patches.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### coff_relocation_patch.f
rtl/crp_pkg.sv
rtl/crp_csr.sv
rtl/crp_alu.sv
rtl/coff_relocation_patch.sv
sim/tb_coff_relocation_patch.sv
